@@ src/sdre_pkg.sv @@
// Shared types, constants and widths for the signed radix digit emitter.
`timescale 1ns / 1ps
`default_nettype none

package sdre_pkg;

  // Field widths fixed by the item format.
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int CFG_W   = 64;
  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 5;
  localparam int CFG_IDX_W = 1;

  // Parameter defaults.
  localparam int MAX_ALPHABET_DEF = 16;
  localparam int DIGIT_DEPTH_DEF  = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 1'b1;

  // Reset contents of the alphabet registers: "0123456789".
  localparam logic [CFG_W-1:0] ALPHA_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0] ALPHA_HIGH_RST = 64'h0000_0000_0000_3938;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Smallest usable alphabet.
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  // Divider: quotient bits retired per cycle, and the divider passes needed for each digit.
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = VALUE_W / DIV_STEP;

  // Result of the shared divider in its final cycle.
  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_res_t;

endpackage

`default_nettype wire

@@ src/sdre_if.sv @@
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps
`default_nettype none

interface sdre_in_if;
  import sdre_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sdre_out_if;
  import sdre_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

@@ src/sdre_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sdre_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ src/sdre_alpha.sv @@
// Alphabet decoder: finds the radix, checks the alphabet and looks up digit symbols.
`timescale 1ns / 1ps
`default_nettype none

module sdre_alpha #(
  parameter int MAX_ALPHABET = sdre_pkg::MAX_ALPHABET_DEF
) (
  input  wire logic [sdre_pkg::CFG_W-1:0]   alpha_low,
  input  wire logic [sdre_pkg::CFG_W-1:0]   alpha_high,
  input  wire logic [sdre_pkg::DIGIT_W-1:0] digit,
  output      logic [sdre_pkg::RADIX_W-1:0] radix,
  output      logic [sdre_pkg::CHAR_W-1:0]  character
);
  import sdre_pkg::*;

  localparam int NCHAR = 16;

  logic [CHAR_W-1:0]  ch [NCHAR];
  logic [RADIX_W-1:0] len;
  logic               ok;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ) ||
           (c >= CHAR_LA && c <= CHAR_LZ);
  endfunction

  always_comb begin
    for (int i = 0; i < NCHAR; i++) begin
      if (i < 8) begin
        ch[i] = alpha_low[8*i +: 8];
      end else begin
        ch[i] = alpha_high[8*(i-8) +: 8];
      end
    end
  end

  // The alphabet ends at the first zero byte within the cap.
  always_comb begin
    len = RADIX_W'(MAX_ALPHABET);
    for (int i = MAX_ALPHABET - 1; i >= 0; i--) begin
      if (ch[i] == CHAR_NUL) begin
        len = RADIX_W'(i);
      end
    end
  end

  always_comb begin
    ok = (len >= MIN_RADIX);
    for (int i = 0; i < NCHAR; i++) begin
      if (RADIX_W'(i) < len && !is_alnum(ch[i])) begin
        ok = 1'b0;
      end
      for (int j = i + 1; j < NCHAR; j++) begin
        if (RADIX_W'(j) < len && ch[i] == ch[j]) begin
          ok = 1'b0;
        end
      end
    end
  end

  assign radix     = ok ? len : '0;
  assign character = ch[digit];

endmodule

`default_nettype wire

@@ src/sdre_div.sv @@
// Shared restoring divider: divides by the radix, several quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sdre_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire logic [sdre_pkg::VALUE_W-1:0] dividend,
  input  wire logic [sdre_pkg::RADIX_W-1:0] radix,
  output      sdre_pkg::div_res_t           res
);
  import sdre_pkg::*;

  localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  logic [VALUE_W-1:0] q_r, q_nxt, q_step;
  logic [DIGIT_W-1:0] rem_r, rem_nxt, rem_step;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               run_r, run_nxt;
  logic               last_cycle;

  // The quotient shifts in at the bottom while the dividend leaves at the top.
  always_comb begin
    logic [RADIX_W-1:0] part;
    q_step   = q_r;
    rem_step = rem_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      part   = {rem_step, q_step[VALUE_W-1]};
      q_step = {q_step[VALUE_W-2:0], 1'b0};
      if (part >= radix) begin
        part      = part - radix;
        q_step[0] = 1'b1;
      end
      rem_step = part[DIGIT_W-1:0];
    end
  end

  assign last_cycle = run_r && (cnt_r == CNT_W'(DIV_CYCLES - 1));

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (load) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      q_nxt   = q_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last_cycle) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done      = last_cycle;
  assign res.quotient  = q_step;
  assign res.remainder = rem_step;

endmodule

`default_nettype wire

@@ src/signed_radix_digit_emitter.sv @@
// Top level: signed integer to text in a configurable radix, one character per item.
//
//   Channel  Direction  Payload                      Handshake
//   in_if    in         value (32 bits, signed)      valid / ready
//   out_if   out        character (8 bits), last     valid / ready
//   cfg_*    in         cfg_index, cfg_data (64)     cfg_we, no wait
//
// An item goes through these steps: capture, an alphabet check, one division per digit in
// the shared divider (eight quotient bits a cycle), a fetch of the top digit while any
// minus sign goes out, and then one character per digit. Zero skips the divider, and an
// unusable alphabet ends the item after the check with no characters sent.
// Reset is synchronous and active low; the digit store needs no clearing.
// A stalled result holds the block; a new item is taken once the last character is registered.
`timescale 1ns / 1ps
`default_nettype none

module signed_radix_digit_emitter #(
  parameter int MAX_ALPHABET = sdre_pkg::MAX_ALPHABET_DEF,
  parameter int DIGIT_DEPTH  = sdre_pkg::DIGIT_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  sdre_in_if.sink                             in_if,
  sdre_out_if.source                          out_if,
  input  wire logic                           cfg_we,
  input  wire logic [sdre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sdre_pkg::CFG_W-1:0]     cfg_data
);
  import sdre_pkg::*;

  // Address width of the digit store, and a count width that can hold its depth.
  localparam int AW = $clog2(DIGIT_DEPTH);
  localparam int CW = $clog2(DIGIT_DEPTH + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_PRE   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CFG_W-1:0]   alpha_low_r, alpha_high_r;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [RADIX_W-1:0] radix_w;
  logic [CHAR_W-1:0]  char_w;
  logic [VALUE_W-1:0] mag;
  logic [CW-1:0]      cnt_inc;
  logic [CW-1:0]      rd_k;
  logic               slot_free;

  logic               div_load;
  logic [VALUE_W-1:0] div_dividend;
  div_res_t           div_res;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DIGIT_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;

  // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r  <= ALPHA_LOW_RST;
      alpha_high_r <= ALPHA_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA_LOW:  alpha_low_r  <= cfg_data;
        REG_ALPHA_HIGH: alpha_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The alphabet decoder gives the radix (zero when the alphabet is unusable)
  // and maps the digit coming out of the store to its symbol.
  sdre_alpha #(
    .MAX_ALPHABET (MAX_ALPHABET)
  ) u_alpha (
    .alpha_low  (alpha_low_r),
    .alpha_high (alpha_high_r),
    .digit      (ram_rdata),
    .radix      (radix_w),
    .character  (char_w)
  );

  // One divider produces every digit in turn; it keeps the magnitude still to
  // divide in its own shift register between digits.
  sdre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (div_dividend),
    .radix    (radix_r),
    .res      (div_res)
  );

  // Digits are stored least significant first and read back in reverse.
  sdre_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The unsigned magnitude handles the most negative value without overflow.
  assign mag       = value_r[VALUE_W-1] ? (~value_r + VALUE_W'(1)) : value_r;
  assign cnt_inc   = cnt_r + CW'(1);
  assign slot_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    radix_nxt     = radix_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_load      = 1'b0;
    div_dividend  = div_res.quotient;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = div_res.remainder;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          value_nxt = in_if.value;
          state_nxt = ST_CHECK;
        end
      end

      // The alphabet is judged now, after any configuration writes have landed.
      ST_CHECK: begin
        if (radix_w == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          radix_nxt = radix_w;
          cnt_nxt   = '0;
          if (mag == '0) begin
            // Zero prints as the alphabet's first symbol.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '0;
            k_nxt     = CW'(1);
            state_nxt = ST_PRE;
          end else begin
            div_load     = 1'b1;
            div_dividend = mag;
            state_nxt    = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_res.done) begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_inc;
          if (div_res.quotient == '0 || cnt_inc == CW'(DIGIT_DEPTH)) begin
            k_nxt     = cnt_inc;
            state_nxt = ST_PRE;
          end else begin
            div_load = 1'b1;
          end
        end
      end

      // The read of the top digit is under way; a minus sign goes out meanwhile.
      ST_PRE: begin
        if (!value_r[VALUE_W-1]) begin
          state_nxt = ST_EMIT;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = char_w;
          out_last_nxt  = (k_r == CW'(1));
          k_nxt         = k_r - CW'(1);
          if (k_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The store is read one place below the next digit count, so the data for
  // the digit about to be emitted is registered before it is needed and holds under a stall.
  assign rd_k      = k_nxt - CW'(1);
  assign ram_raddr = rd_k[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r    <= value_nxt;
    radix_r    <= radix_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_if.ready      = (state_r == ST_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.character = out_char_r;
  assign out_if.last      = out_last_r;

endmodule

`default_nettype wire

@@ src/sdre_chk.sv @@
// Port-level checker for the signed radix digit emitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sdre_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [sdre_pkg::CHAR_W-1:0]   out_character,
  input wire logic                          out_last
);
  import sdre_pkg::*;

  // A waiting result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("result item changed while stalled");

  // One item at a time: an accepted item closes the input for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after an accept");

  // The sign always precedes at least one digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_character != CHAR_MINUS)
    else $error("minus sign marked as final character");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind signed_radix_digit_emitter sdre_chk u_sdre_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_character (out_if.character),
  .out_last      (out_if.last)
);

`default_nettype wire

@@ tb/tb_signed_radix_digit_emitter.sv @@
// Self-checking testbench for the signed radix digit emitter.
`timescale 1ns / 1ps

module tb_signed_radix_digit_emitter;
  import sdre_pkg::*;

  // Clock and pacing.
  localparam int CLK_PERIOD   = 4;
  localparam int IDLE_PCT     = 6;       // chance in a hundred of an idle cycle on either side
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off, enough to fill the block
  localparam int QUIET_CYCLES = 250;     // quiet spell, long enough for the longest item
  localparam int RANDOM_ITEMS = 50;
  localparam longint LIMIT_NS = 3_000_000;

  // Ways of spoiling an otherwise good alphabet.
  typedef enum int {FLAW_SHORT, FLAW_SYMBOL, FLAW_REPEAT} alpha_flaw_t;

  // One character of an expected run.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } glyph_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  sdre_in_if  in_if ();
  sdre_out_if out_if ();

  signed_radix_digit_emitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the two alphabet registers, as they stand after reset.
  logic [CFG_W-1:0] alpha_lo = ALPHA_LOW_RST;
  logic [CFG_W-1:0] alpha_hi = ALPHA_HIGH_RST;

  // Characters still owed by the block, oldest first.
  glyph_t glyphs_due[$];

  int unsigned mismatches = 0;

  // When set, neither side idles; used for a back-to-back stretch.
  bit steady = 1'b0;

  // The test bumps hold_req to ask for a long hold-off; the receiver process
  // notices the change and counts the cycles itself.
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Character k of the configured alphabet.
  function automatic logic [CHAR_W-1:0] alpha_at(int k);
    if (k < 8) begin
      return alpha_lo[8*k +: 8];
    end else begin
      return alpha_hi[8*(k-8) +: 8];
    end
  endfunction

  function automatic bit is_alnum(logic [CHAR_W-1:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ) ||
           (c >= CHAR_LA && c <= CHAR_LZ);
  endfunction

  // Radix given by the current alphabet, or zero when the alphabet is unusable.
  // The alphabet stops at its first NUL byte or after sixteen characters.
  function automatic int alphabet_size();
    int len;
    len = 0;
    while (len < MAX_ALPHABET_DEF && alpha_at(len) != CHAR_NUL) len++;
    if (len < int'(MIN_RADIX)) return 0;
    for (int i = 0; i < len; i++) begin
      if (!is_alnum(alpha_at(i))) return 0;
      for (int j = i + 1; j < len; j++) begin
        if (alpha_at(i) == alpha_at(j)) return 0;
      end
    end
    return len;
  endfunction

  // Works out the run of characters for one accepted value and queues it.
  // Digits come from repeated division of the unsigned magnitude, so the most
  // negative value prints correctly; zero gives a single digit.
  function automatic void render_value(logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [DIGIT_W-1:0] digits [DIGIT_DEPTH_DEF];
    int                 nd;
    int                 radix;
    radix = alphabet_size();
    if (radix == 0) return;                // unusable alphabet: nothing comes out
    base = VALUE_W'(radix);
    raw  = v;
    mag  = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
    nd   = 0;
    if (mag == 0) begin
      digits[0] = '0;
      nd = 1;
    end
    while (mag != 0 && nd < DIGIT_DEPTH_DEF) begin
      digits[nd] = DIGIT_W'(mag % base);
      nd++;
      mag = mag / base;
    end
    if (raw[VALUE_W-1]) begin
      glyphs_due.push_back('{character: CHAR_MINUS, last: 1'b0});
    end
    for (int k = nd; k > 0; k--) begin
      glyphs_due.push_back('{character: alpha_at(int'(digits[k-1])), last: (k == 1)});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Packs a text into the two alphabet registers, first character lowest.
  function automatic logic [2*CFG_W-1:0] text_alphabet(string s);
    logic [2*CFG_W-1:0] a;
    a = '0;
    for (int i = 0; i < s.len() && i < MAX_ALPHABET_DEF; i++) a[8*i +: 8] = s[i];
    return a;
  endfunction

  // A random good alphabet of the given length: distinct alphanumerics, then a
  // NUL terminator, optionally followed by junk that the block must ignore.
  function automatic logic [2*CFG_W-1:0] pick_alphabet(int unsigned len, bit junk_tail);
    logic [CHAR_W-1:0]  pool [62];
    logic [CHAR_W-1:0]  t;
    logic [2*CFG_W-1:0] a;
    int unsigned        j;
    for (int i = 0; i < 10; i++) pool[i] = CHAR_0 + CHAR_W'(i);
    for (int i = 0; i < 26; i++) pool[10 + i] = CHAR_UA + CHAR_W'(i);
    for (int i = 0; i < 26; i++) pool[36 + i] = CHAR_LA + CHAR_W'(i);
    a = '0;
    for (int i = 0; i < int'(len); i++) begin
      j = $urandom_range(61, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
      a[8*i +: 8] = pool[i];
    end
    if (junk_tail) begin
      for (int i = len + 1; i < MAX_ALPHABET_DEF; i++) a[8*i +: 8] = CHAR_W'($urandom);
    end
    return a;
  endfunction

  // Turns a good alphabet into a bad one in one of several ways.
  function automatic logic [2*CFG_W-1:0] spoil_alphabet(logic [2*CFG_W-1:0] a,
                                                        int unsigned len);
    alpha_flaw_t       flaw;
    int unsigned       pos;
    int unsigned       other;
    logic [CHAR_W-1:0] sym;
    flaw = alpha_flaw_t'($urandom_range(2));
    case (flaw)
      FLAW_SHORT: begin
        pos = $urandom_range(1);
        a[8*pos +: 8] = CHAR_NUL;
      end
      FLAW_SYMBOL: begin
        pos = $urandom_range(len - 1);
        do sym = CHAR_W'($urandom_range(255, 1)); while (is_alnum(sym));
        a[8*pos +: 8] = sym;
      end
      default: begin
        pos   = $urandom_range(len - 1);
        other = (pos + 1 + $urandom_range(len - 2)) % len;
        a[8*other +: 8] = a[8*pos +: 8];
      end
    endcase
    return a;
  endfunction

  // Values weighted towards the interesting places: full-width random, small
  // numbers either side of zero, the extremes, and random magnitudes.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] r;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6: return int'($urandom_range(600)) - 300;
      7: begin
        case ($urandom_range(4))
          0: return 0;
          1: return 1;
          2: return -1;
          3: return 32'sh7FFF_FFFF;
          default: return 32'sh8000_0000;
        endcase
      end
      default: begin
        r = $urandom >> $urandom_range(31);
        return $urandom_range(1) ? -r : r;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Shared tasks. Each starts and ends at a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one value and waits for the block to take it. Idle cycles in front
  // carry a junk value, which must be ignored while valid is low.
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      in_if.value <= $urandom;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    render_value(v);
    @(negedge clk);
  endtask

  // Sender pause: nothing is offered until every owed character has come.
  task automatic wait_results();
    in_if.valid <= 1'b0;
    while (glyphs_due.size() != 0) @(negedge clk);
  endtask

  // Full idle: besides the owed characters, an item under a bad alphabet may
  // still be inside the block, so allow a further quiet spell.
  task automatic settle();
    wait_results();
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Writes both alphabet registers, only ever with the block idle.
  task automatic set_alphabet(input logic [2*CFG_W-1:0] a);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ALPHA_LOW;
    cfg_data  <= a[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_ALPHA_HIGH;
    cfg_data  <= a[2*CFG_W-1:CFG_W];
    @(negedge clk);
    cfg_we    <= 1'b0;
    alpha_lo  = a[CFG_W-1:0];
    alpha_hi  = a[2*CFG_W-1:CFG_W];
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge. Mostly ready, with the odd
  // idle cycle, and a long hold-off whenever the test asks for one.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!steady && $urandom_range(99) < IDLE_PCT) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Each character taken is compared, field by field, with the oldest one owed.
  always @(posedge clk) begin : check_results
    glyph_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
      if (glyphs_due.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                  out_if.character, out_if.last));
      end else begin
        want = glyphs_due.pop_front();
        if (out_if.character !== want.character) begin
          report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                    out_if.character, want.character));
        end
        if (out_if.last !== want.last) begin
          report_mismatch($sformatf("last %0b on character 0x%02h, wanted %0b",
                                    out_if.last, want.character, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The decimal alphabet that reset leaves: zero, the units either side of it,
  // a two-digit value and both ends of the range.
  task automatic test_reset_alphabet();
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(10);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
  endtask

  // Radix two gives the longest runs: the most negative value is a sign and
  // thirty-two digits.
  task automatic test_binary_alphabet();
    set_alphabet(text_alphabet("01"));
    send_value(32'sh8000_0000);
    send_value(-1);
    send_value(32'sh7FFF_FFFF);
  endtask

  // Sixteen characters with no terminator: the alphabet ends at the cap.
  task automatic test_full_alphabet();
    set_alphabet(text_alphabet("0123456789ABCDEF"));
    send_value(32'sh8000_0000);
    send_value(32'shDEAD_BEEF);
    send_value(32'sh0000_CAFE);
  endtask

  // Letters only, odd radix; zero must print the first letter.
  task automatic test_letter_alphabet();
    set_alphabet(text_alphabet("aZz"));
    send_value(0);
    send_value(5);
    send_value(-7);
  endtask

  // Eight characters in the low register, the high register all zeros.
  task automatic test_octal_alphabet();
    set_alphabet(text_alphabet("01234567"));
    send_value(-8);
  endtask

  // Alphabets the block must refuse: register extremes, too short, a repeated
  // character, a character that is not alphanumeric. No characters may come out.
  task automatic test_bad_alphabets();
    set_alphabet({2*CFG_W{1'b1}});
    send_value(pick_value());
    set_alphabet('0);
    send_value(pick_value());
    set_alphabet(text_alphabet("7"));
    send_value(pick_value());
    set_alphabet(text_alphabet("0120"));
    send_value(pick_value());
    set_alphabet(text_alphabet("01-"));
    send_value(pick_value());
  endtask

  // The receiver stops for a long spell while values keep coming, so the block
  // backs up and holds its input off. A small radix makes the runs long.
  task automatic test_output_backpressure();
    set_alphabet(pick_alphabet($urandom_range(4, 2), 1'b0));
    hold_req++;
    repeat (8) send_value(pick_value());
    wait_results();
  endtask

  // Short bursts, each followed by a pause until every character is home.
  task automatic test_sender_pause();
    set_alphabet(pick_alphabet($urandom_range(16, 2), 1'b1));
    repeat (3) begin
      repeat (3) send_value(pick_value());
      wait_results();
    end
  endtask

  // Neither side idles for a whole stretch, so items run back to back.
  task automatic test_back_to_back();
    set_alphabet(pick_alphabet($urandom_range(16, 2), 1'b0));
    steady = 1'b1;
    repeat (20) send_value(pick_value());
    wait_results();
    steady = 1'b0;
  endtask

  // Phases of random values, each under a fresh alphabet; most alphabets are
  // good, some are spoiled. Only values under a good alphabet count.
  task automatic test_random_phases();
    int unsigned        counted;
    int unsigned        batch;
    int unsigned        len;
    logic [2*CFG_W-1:0] a;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      len = $urandom_range(16, 2);
      a   = pick_alphabet(len, $urandom_range(1));
      if ($urandom_range(99) < 15) a = spoil_alphabet(a, len);
      set_alphabet(a);
      batch = (alphabet_size() == 0) ? $urandom_range(4, 2) : $urandom_range(14, 6);
      repeat (batch) send_value(pick_value());
      if (alphabet_size() != 0) counted += batch;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_ALPHA_LOW;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_alphabet();
    test_binary_alphabet();
    test_full_alphabet();
    test_letter_alphabet();
    test_octal_alphabet();
    test_bad_alphabets();
    test_output_backpressure();
    test_sender_pause();
    test_back_to_back();
    test_random_phases();

    // Everything owed must arrive, and nothing more in the quiet spell after.
    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
